// File: rtl/vsca_pkg.sv
// shared types, constants and codes of the voice allocator
package vsca_pkg;

  localparam int unsigned VOICES  = 128;
  localparam int unsigned IDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CNT_W   = $clog2(VOICES + 1);
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [1:0]  OP_START = 2'd0;
  localparam logic [1:0]  OP_STOP  = 2'd1;
  localparam logic [1:0]  OP_CLEAR = 2'd2;

  localparam logic [3:0]  SLOT_NONE = 4'h0;
  localparam logic [3:0]  SLOT_ANY  = 4'hF;
  localparam logic [31:0] LIFE_MAX  = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_STOP,
    CMD_CLEAR,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [15:0] entity;
    logic [3:0]  slot;
    logic [30:0] now;
    logic [31:0] end_time;
    logic        audible;
    logic        slot_any;
    logic        slot_none;
  } cmd_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [3:0]  slot;
    logic [31:0] end_time;
    logic        active;
  } voice_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/vsca_ram.sv
// generic single write port ram with registered read
module vsca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/vsca_front.sv
// request intake: decodes each word and queues it for the scan engine
module vsca_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           opcode_i,
  input  logic [15:0]          entity_i,
  input  logic [3:0]           slot_i,
  input  logic [30:0]          now_time_i,
  input  logic [23:0]          sound_length_i,
  input  logic                 audible_i,
  output vsca_pkg::cmd_t       cmd_o,
  output logic                 cmd_valid_o,
  input  logic                 cmd_pop_i,
  output vsca_pkg::q_stat_t    stat_o
);

  vsca_pkg::cmd_t                    q_mem_q [vsca_pkg::QDEPTH];
  logic [vsca_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [vsca_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [vsca_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  vsca_pkg::cmd_t                    dec;
  logic                              push, pop, full, empty;

  always_comb begin
    dec           = '0;
    dec.entity    = entity_i;
    dec.slot      = slot_i;
    dec.now       = now_time_i;
    dec.end_time  = {1'b0, now_time_i} + {8'd0, sound_length_i};
    dec.audible   = audible_i;
    dec.slot_any  = (slot_i == vsca_pkg::SLOT_ANY);
    dec.slot_none = (slot_i == vsca_pkg::SLOT_NONE);
    unique case (opcode_i)
      vsca_pkg::OP_START: dec.kind = vsca_pkg::CMD_START;
      vsca_pkg::OP_STOP:  dec.kind = vsca_pkg::CMD_STOP;
      vsca_pkg::OP_CLEAR: dec.kind = vsca_pkg::CMD_CLEAR;
      default:            dec.kind = vsca_pkg::CMD_NOP;
    endcase
  end

  assign full  = (cnt_q == vsca_pkg::QCNT_W'(vsca_pkg::QDEPTH));
  assign empty = (cnt_q == '0);
  assign push  = start_i && !full;
  assign pop   = cmd_pop_i && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == vsca_pkg::QPTR_W'(vsca_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == vsca_pkg::QPTR_W'(vsca_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= dec;
    end
  end

  assign busy_o       = full;
  assign cmd_o        = q_mem_q[rd_ptr_q];
  assign cmd_valid_o  = !empty;
  assign stat_o.full  = full;
  assign stat_o.empty = empty;

endmodule

// File: rtl/vsca_back.sv
// scan engine: walks the voice table, picks a voice and writes it back
module vsca_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     player_i,
  input  vsca_pkg::cmd_t  cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_pop_o,
  output logic            done_o,
  output logic            granted_o,
  output logic [6:0]      voice_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]                    state_q, state_d;
  vsca_pkg::cmd_t                cmd_q, cmd_d;
  logic [vsca_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          rd_vld_q, rd_vld_d;
  logic [vsca_pkg::IDX_W-1:0]    rd_idx_q, rd_idx_d;
  logic                          ent_vld_q, ent_vld_d;
  logic [31:0]                   best_q, best_d;
  logic [vsca_pkg::IDX_W-1:0]    pick_q, pick_d;
  logic                          pick_vld_q, pick_vld_d;
  logic [vsca_pkg::VOICES-1:0]   valid_q, valid_d;
  logic                          done_q, done_d;
  logic                          granted_q, granted_d;
  logic [6:0]                    voice_q, voice_d;

  logic                          issue, hit, protect;
  logic [31:0]                   life;
  vsca_pkg::voice_t              rdata, entry, wdata;
  logic                          we;

  vsca_ram #(
    .WIDTH ($bits(vsca_pkg::voice_t)),
    .DEPTH (vsca_pkg::VOICES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pick_q),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (cnt_q[vsca_pkg::IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign entry = ent_vld_q ? rdata : '0;
  assign life  = entry.end_time - {1'b0, cmd_q.now};

  always_comb begin
    hit     = 1'b0;
    protect = 1'b0;
    if (cmd_q.kind == vsca_pkg::CMD_START) begin
      hit = !cmd_q.slot_none && (entry.owner == cmd_q.entity) &&
            ((entry.slot == cmd_q.slot) || cmd_q.slot_any);
      protect = (entry.owner == player_i) && (cmd_q.entity != player_i) && entry.active;
    end else begin
      hit = (entry.owner == cmd_q.entity) && (entry.slot == cmd_q.slot);
    end
  end

  always_comb begin
    wdata.owner    = cmd_q.entity;
    wdata.slot     = cmd_q.slot;
    wdata.end_time = '0;
    wdata.active   = 1'b0;
    if ((cmd_q.kind == vsca_pkg::CMD_START) && cmd_q.audible) begin
      wdata.end_time = cmd_q.end_time;
      wdata.active   = 1'b1;
    end
  end

  assign issue = (state_q == ST_SCAN) && (cnt_q < vsca_pkg::CNT_W'(vsca_pkg::VOICES)) &&
                 !(rd_vld_q && hit);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    ent_vld_d  = ent_vld_q;
    best_d     = best_q;
    pick_d     = pick_q;
    pick_vld_d = pick_vld_q;
    valid_d    = valid_q;
    done_d     = 1'b0;
    granted_d  = 1'b0;
    voice_d    = '0;
    cmd_pop_o  = 1'b0;
    we         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          cnt_d      = '0;
          best_d     = vsca_pkg::LIFE_MAX;
          pick_vld_d = 1'b0;
          case (cmd_i.kind) inside
            vsca_pkg::CMD_START, vsca_pkg::CMD_STOP: begin
              state_d = ST_SCAN;
            end
            vsca_pkg::CMD_CLEAR: begin
              valid_d = '0;
              done_d  = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_d     = cnt_q + 1'b1;
          rd_vld_d  = 1'b1;
          rd_idx_d  = cnt_q[vsca_pkg::IDX_W-1:0];
          ent_vld_d = valid_q[cnt_q[vsca_pkg::IDX_W-1:0]];
        end
        if (rd_vld_q) begin
          if (hit) begin
            pick_d     = rd_idx_q;
            pick_vld_d = 1'b1;
            state_d    = ST_WRITE;
          end else begin
            if ((cmd_q.kind == vsca_pkg::CMD_START) && !protect &&
                ($signed(life) < $signed(best_q))) begin
              best_d     = life;
              pick_d     = rd_idx_q;
              pick_vld_d = 1'b1;
            end
            if (rd_idx_q == vsca_pkg::IDX_W'(vsca_pkg::VOICES - 1)) begin
              state_d = ST_WRITE;
            end
          end
        end
      end
      ST_WRITE: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (pick_vld_q) begin
          we              = 1'b1;
          valid_d[pick_q] = 1'b1;
          granted_d       = 1'b1;
          voice_d         = 7'(pick_q);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      pick_vld_q <= 1'b0;
      valid_q    <= '0;
      done_q     <= 1'b0;
      granted_q  <= 1'b0;
      voice_q    <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_vld_d;
      pick_vld_q <= pick_vld_d;
      valid_q    <= valid_d;
      done_q     <= done_d;
      granted_q  <= granted_d;
      voice_q    <= voice_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    rd_idx_q  <= rd_idx_d;
    ent_vld_q <= ent_vld_d;
    best_q    <= best_d;
    pick_q    <= pick_d;
  end

  assign done_o    = done_q;
  assign granted_o = granted_q;
  assign voice_o   = voice_q;

endmodule

// File: rtl/voice_steal_channel_allocator.sv
// top level of the voice allocator with voice stealing
//
//  channel   | handshake              | words
//  ----------+------------------------+------------------------------------------
//  request   | start_i / busy_o       | opcode, entity, slot, now_time, length, audible
//  result    | done_o (one-cycle)     | granted, voice
//  config    | cfg_we_i               | player entity (16 bits)
//
// start and stop walk the table through one ram read port; the result strobe
// follows the walk, the scan engine is held while it runs, and an owner match
// ends the walk early; stop-all and unknown opcodes do not walk the table, and
// the table is clear right after reset since per-voice valid bits are cleared
// by rst_ni
// a two-word queue takes requests while a walk runs; busy_o rises when it is full
// results cannot be held off and appear for one cycle on done_o
module voice_steal_channel_allocator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         opcode_i,
  input  logic [15:0]        entity_i,
  input  logic signed [3:0]  slot_i,
  input  logic [30:0]        now_time_i,
  input  logic [23:0]        sound_length_i,
  input  logic               audible_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               done_o,
  output logic               granted_o,
  output logic [6:0]         voice_o
);

  logic [15:0]        player_q;
  vsca_pkg::cmd_t     cmd;
  logic               cmd_valid, cmd_pop;
  vsca_pkg::q_stat_t  q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_q <= '0;
    end else if (cfg_we_i) begin
      player_q <= cfg_wdata_i;
    end
  end

  vsca_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .entity_i       (entity_i),
    .slot_i         (slot_i),
    .now_time_i     (now_time_i),
    .sound_length_i (sound_length_i),
    .audible_i      (audible_i),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_valid),
    .cmd_pop_i      (cmd_pop),
    .stat_o         (q_stat)
  );

  vsca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .player_i    (player_q),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .done_o      (done_o),
    .granted_o   (granted_o),
    .voice_o     (voice_o)
  );

  a_grant_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    granted_o |-> done_o)
    else $error("grant without result strobe");

  a_denied_voice_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !granted_o) |-> (voice_o == 7'd0))
    else $error("denied result carries a voice");

  a_busy_means_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (!q_stat.empty && cmd_valid))
    else $error("busy with an empty queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && q_stat.empty) |=> !done_o)
    else $error("result from an empty queue");

endmodule

// File: dv/voice_steal_channel_allocator_tb.sv
// self-checking testbench of the voice allocator: predicted grant words against done words
module voice_steal_channel_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VOICES    = vsca_pkg::VOICES;
  localparam logic [1:0]  OP_START  = vsca_pkg::OP_START;
  localparam logic [1:0]  OP_STOP   = vsca_pkg::OP_STOP;
  localparam logic [1:0]  OP_CLEAR  = vsca_pkg::OP_CLEAR;
  localparam logic [3:0]  SLOT_NONE = vsca_pkg::SLOT_NONE;
  localparam logic [3:0]  SLOT_ANY  = vsca_pkg::SLOT_ANY;
  localparam logic [31:0] LIFE_MAX  = vsca_pkg::LIFE_MAX;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         STALL_LIMIT = 4000;
  localparam int         TAIL_CYCLES = 140;

  typedef struct {
    logic       granted;
    logic [6:0] voice;
  } grant_t;

  typedef struct packed {
    logic [15:0] ent;
    logic [3:0]  slot;
  } owner_slot_t;

  class voice_table_model;
    logic [15:0] player;
    logic [15:0] owner_tab  [VOICES];
    logic [3:0]  slot_tab   [VOICES];
    logic [31:0] end_tab    [VOICES];
    logic        active_tab [VOICES];
    grant_t      pending_grants [$];
    int          mismatches;

    function new();
      player     = '0;
      mismatches = 0;
      clear_all();
    endfunction

    function void clear_all();
      for (int i = 0; i < VOICES; i++) begin
        owner_tab[i]  = '0;
        slot_tab[i]   = '0;
        end_tab[i]    = '0;
        active_tab[i] = 1'b0;
      end
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] ent, logic [3:0] slot,
                               logic [30:0] now, logic [23:0] len, logic aud);
      grant_t      g;
      int          pick;
      int          best;
      int          life;
      logic [31:0] diff;
      bit          hit;
      g.granted = 1'b0;
      g.voice   = '0;
      hit       = 1'b0;
      if (op == OP_START) begin
        pick = -1;
        best = int'(LIFE_MAX);
        for (int i = 0; i < VOICES && !hit; i++) begin
          if (slot != SLOT_NONE && owner_tab[i] == ent &&
              (slot_tab[i] == slot || slot == SLOT_ANY)) begin
            pick = i;
            hit  = 1'b1;
          end else if (!(owner_tab[i] == player && ent != player && active_tab[i])) begin
            diff = end_tab[i] - {1'b0, now};
            life = signed'(diff);
            if (life < best) begin
              best = life;
              pick = i;
            end
          end
        end
        if (pick >= 0) begin
          owner_tab[pick]  = ent;
          slot_tab[pick]   = slot;
          end_tab[pick]    = '0;
          active_tab[pick] = 1'b0;
          if (aud) begin
            active_tab[pick] = 1'b1;
            end_tab[pick]    = {1'b0, now} + {8'b0, len};
          end
          g.granted = 1'b1;
          g.voice   = 7'(pick);
        end
      end else if (op == OP_STOP) begin
        for (int i = 0; i < VOICES && !hit; i++) begin
          if (owner_tab[i] == ent && slot_tab[i] == slot) begin
            end_tab[i]    = '0;
            active_tab[i] = 1'b0;
            g.granted     = 1'b1;
            g.voice       = 7'(i);
            hit           = 1'b1;
          end
        end
      end else if (op == OP_CLEAR) begin
        clear_all();
      end
      pending_grants.push_back(g);
    endfunction

    function void check_grant(logic granted, logic [6:0] voice);
      grant_t exp_g;
      if (pending_grants.size() == 0) begin
        $display("%0t: done word with none expected, actual granted %0b voice %0d",
                 $time, granted, voice);
        mismatches++;
      end else begin
        exp_g = pending_grants.pop_front();
        if (granted !== exp_g.granted) begin
          $display("%0t: granted expected %0b actual %0b", $time, exp_g.granted, granted);
          mismatches++;
        end
        if (voice !== exp_g.voice) begin
          $display("%0t: voice expected %0d actual %0d", $time, exp_g.voice, voice);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic [1:0]         opcode_i       = '0;
  logic [15:0]        entity_i       = '0;
  logic signed [3:0]  slot_i         = '0;
  logic [30:0]        now_time_i     = '0;
  logic [23:0]        sound_length_i = '0;
  logic               audible_i      = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [15:0]        cfg_wdata_i    = '0;
  logic               busy_o;
  logic               done_o;
  logic               granted_o;
  logic [6:0]         voice_o;

  voice_table_model   tbl;
  logic [30:0]        clock_now;
  logic [15:0]        entity_pool [6];
  owner_slot_t        recent_sounds [$];
  bit                 quiet;
  int                 stall_cycles = 0;

  voice_steal_channel_allocator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .entity_i       (entity_i),
    .slot_i         (slot_i),
    .now_time_i     (now_time_i),
    .sound_length_i (sound_length_i),
    .audible_i      (audible_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .granted_o      (granted_o),
    .voice_o        (voice_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      tbl.check_grant(granted_o, voice_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("voice_steal_channel_allocator: mismatch");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [15:0] ent,
                              input logic [3:0] slot, input logic [30:0] now,
                              input logic [23:0] len, input logic aud);
    int gap;
    start_i        <= 1'b1;
    opcode_i       <= op;
    entity_i       <= ent;
    slot_i         <= slot;
    now_time_i     <= now;
    sound_length_i <= len;
    audible_i      <= aud;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    tbl.note_request(op, ent, slot, now, len, aud);
    if (op == OP_START && slot != SLOT_NONE) begin
      recent_sounds.push_back({ent, slot});
      if (recent_sounds.size() > 24) recent_sounds.pop_front();
    end
    if (!quiet && $urandom_range(0, 99) < 37) begin
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 160);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (tbl.pending_grants.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_player(input logic [15:0] value);
    start_i <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tbl.player  = value;
  endtask

  function automatic logic [15:0] pick_entity();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return tbl.player;
    if (r < 80) return entity_pool[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  function automatic logic [3:0] pick_slot();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 4'($urandom_range(1, 7));
    if (r < 75) return SLOT_NONE;
    if (r < 90) return SLOT_ANY;
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic random_burst(input int n);
    int          r;
    logic [1:0]  op;
    logic [15:0] ent;
    logic [3:0]  slot;
    logic [23:0] len;
    logic        aud;
    owner_slot_t os;
    repeat (n) begin
      r  = $urandom_range(0, 99);
      op = (r < 65) ? OP_START : (r < 95) ? OP_STOP : (r < 97) ? OP_CLEAR : OP_SPARE;
      ent  = pick_entity();
      slot = pick_slot();
      if (op == OP_STOP && recent_sounds.size() != 0 && $urandom_range(0, 9) < 7) begin
        os   = recent_sounds[$urandom_range(0, recent_sounds.size() - 1)];
        ent  = os.ent;
        slot = os.slot;
      end
      if ($urandom_range(0, 19) == 0) begin
        clock_now = 31'($urandom);
      end else begin
        clock_now = clock_now + 31'($urandom_range(0, 3000));
      end
      r   = $urandom_range(0, 19);
      len = (r < 16) ? 24'($urandom_range(0, 20000)) : (r < 19) ? 24'($urandom) : '0;
      aud = ($urandom_range(0, 99) < 85);
      send_request(op, ent, slot, clock_now, len, aud);
    end
  endtask

  // fill every voice with the listener, then ask for one more
  task automatic player_fill(input bit max_life);
    logic [30:0] fill_now;
    logic [23:0] fill_len;
    fill_now = max_life ? 31'h7f00_0000 : clock_now;
    fill_len = max_life ? 24'hff_ffff : 24'hf0_0000;
    send_request(OP_CLEAR, tbl.player, SLOT_NONE, clock_now, '0, 1'b0);
    repeat (VOICES) send_request(OP_START, tbl.player, SLOT_NONE, fill_now, fill_len, 1'b1);
    send_request(OP_START, tbl.player ^ 16'h0001, 4'h3, clock_now, 24'd100, 1'b1);
    if (max_life) begin
      send_request(OP_START, tbl.player, SLOT_NONE, 31'h0, 24'd100, 1'b1);
    end
    send_request(OP_CLEAR, tbl.player, SLOT_NONE, clock_now, '0, 1'b0);
  endtask

  initial begin
    logic [15:0] phase_player [8];
    tbl       = new();
    clock_now = '0;
    quiet     = 1'b0;
    entity_pool[0] = 16'h0000;
    entity_pool[1] = 16'hffff;
    for (int i = 2; i < 6; i++) entity_pool[i] = 16'($urandom);
    phase_player[0] = 16'h0000;
    phase_player[1] = 16'hffff;
    phase_player[2] = 16'($urandom);
    phase_player[3] = entity_pool[2];
    phase_player[4] = 16'($urandom);
    phase_player[5] = 16'hffff;
    phase_player[6] = entity_pool[3];
    phase_player[7] = 16'h0000;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_START, 16'h0000, SLOT_NONE, 31'h0, 24'h0, 1'b0);
    send_request(OP_START, 16'hffff, SLOT_ANY, 31'h7fff_ffff, 24'hff_ffff, 1'b1);
    send_request(OP_START, 16'd5, 4'd7, 31'd100, 24'd1000, 1'b1);
    // same owner and slot takes the voice over
    send_request(OP_START, 16'd5, 4'd7, 31'd200, 24'd500, 1'b1);
    send_request(OP_START, 16'd5, SLOT_ANY, 31'd300, 24'd500, 1'b1);
    send_request(OP_START, 16'd5, SLOT_NONE, 31'd400, 24'd50, 1'b1);
    send_request(OP_START, 16'd5, SLOT_NONE, 31'd400, 24'd50, 1'b0);
    send_request(OP_STOP, 16'd5, SLOT_NONE, 31'd0, 24'd0, 1'b0);
    send_request(OP_STOP, 16'd5, 4'd3, 31'd0, 24'd0, 1'b0);
    send_request(OP_STOP, 16'd5, SLOT_ANY, 31'd0, 24'd0, 1'b0);
    send_request(OP_STOP, 16'hffff, SLOT_ANY, 31'd0, 24'd0, 1'b0);
    send_request(OP_STOP, 16'h0000, SLOT_NONE, 31'd0, 24'd0, 1'b0);
    send_request(OP_SPARE, 16'hffff, SLOT_ANY, 31'h7fff_ffff, 24'hff_ffff, 1'b1);
    send_request(OP_START, 16'd9, 4'h8, 31'h7fff_fff0, 24'hff_ffff, 1'b1);
    send_request(OP_START, 16'd9, 4'h9, 31'h7fff_fff0, 24'd10, 1'b1);
    send_request(OP_STOP, 16'd9, 4'h8, 31'd0, 24'd0, 1'b0);
    send_request(OP_CLEAR, 16'hffff, SLOT_ANY, 31'h7fff_ffff, 24'hff_ffff, 1'b1);
    send_request(OP_STOP, 16'd9, 4'h9, 31'd0, 24'd0, 1'b0);
    send_request(OP_START, 16'h1234, 4'd1, 31'h5555_5555, 24'haa_aaaa, 1'b1);
    send_request(OP_START, 16'hedcb, 4'd6, 31'h2aaa_aaaa, 24'h55_5555, 1'b1);

    for (int p = 0; p < 8; p++) begin
      set_player(phase_player[p]);
      quiet = (p == 4);
      if (p == 2) player_fill(1'b0);
      if (p == 5) player_fill(1'b1);
      random_burst(165);
    end

    start_i <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tbl.mismatches == 0) begin
      $display("voice_steal_channel_allocator: match");
    end else begin
      $display("voice_steal_channel_allocator: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/vsca_pkg.sv
rtl/vsca_ram.sv
rtl/vsca_front.sv
rtl/vsca_back.sv
rtl/voice_steal_channel_allocator.sv
dv/voice_steal_channel_allocator_tb.sv
